// File: sv/ocsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocsc_pkg
// Shared types, sequencer states and the saturation helper for the
// observer consensus speed controller.
// ----------------------------------------------------------------------------
package ocsc_pkg;

   localparam int CFG_W   = 24;
   localparam int POS_W   = 32;
   localparam int OP_A_W  = 34;
   localparam int OP_B_W  = 25;
   localparam int PROD_W  = OP_A_W + OP_B_W + 1;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_OBSERVER_GAIN  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSENSUS_GAIN = 1'b1;

   localparam logic [CFG_W-1:0] OBSERVER_GAIN_RST  = 24'd196608;
   localparam logic [CFG_W-1:0] CONSENSUS_GAIN_RST = 24'd26214;

   localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

   typedef struct packed {
      logic signed [POS_W-1:0] value;
      logic                    clip;
   } sat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PROD,
      ST_IDX_LO,
      ST_IDX_HI,
      ST_WEIGHT,
      ST_ERR,
      ST_GAIN_Z,
      ST_DVEL,
      ST_VEL,
      ST_DPOS,
      ST_POS,
      ST_GAP,
      ST_PGAIN1,
      ST_PGAIN2,
      ST_VGAIN,
      ST_ACCUM,
      ST_DONE
   } state_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      if (v > SAT_MAX) begin
         r.value = SAT_MAX[POS_W-1:0];
         r.clip  = 1'b1;
      end else if (v < SAT_MIN) begin
         r.value = SAT_MIN[POS_W-1:0];
         r.clip  = 1'b1;
      end else begin
         r.value = v[POS_W-1:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

endpackage

// File: sv/ocsc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocsc_req_if
// Tick channel: interval, measured positions and measurement ages.
// ----------------------------------------------------------------------------
interface ocsc_req_if;
   logic               valid;
   logic               ready;
   logic [23:0]        tick_interval;
   logic signed [31:0] pos_self;
   logic signed [31:0] pos_first_nbr;
   logic signed [31:0] pos_second_nbr;
   logic [23:0]        age_self;
   logic [23:0]        age_first_nbr;
   logic [23:0]        age_second_nbr;

   modport source (output valid, tick_interval, pos_self, pos_first_nbr, pos_second_nbr,
                   age_self, age_first_nbr, age_second_nbr, input ready);
   modport sink (input valid, tick_interval, pos_self, pos_first_nbr, pos_second_nbr,
                 age_self, age_first_nbr, age_second_nbr, output ready);
endinterface

// File: sv/ocsc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocsc_rsp_if
// Result channel: speed command and saturation flag.
// ----------------------------------------------------------------------------
interface ocsc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] speed_command;
   logic               clipped;

   modport source (output valid, speed_command, clipped, input ready);
   modport sink (input valid, speed_command, clipped, output ready);
endinterface

// File: sv/observer_consensus_speed_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// observer_consensus_speed_controller_top
// Observer based consensus speed controller, one result beat per tick beat.
// ----------------------------------------------------------------------------
// Each tick beat runs three observer updates (self, first and second
// neighbor) and one consensus update through a single shared 34x25
// multiplier under a small sequencer. Each agent steps through age
// weighting, exp lookup, error and Euler updates, then the consensus step
// and result load follow; req_chan.ready is high only while the sequencer
// is idle, so a new tick is taken only once the previous one has finished.
// The result sits in an output register, so the next tick is taken while
// a result still waits; the sequencer holds at its last step only if the
// previous result has not left yet. Gains are written through the csr_
// port (index 0 observer gain, index 1 consensus gain); the user must write
// them only while the block is idle, as the block does not enforce it. All
// arithmetic is Q16.16 by default with each error, gain, gap and Euler result
// clamped to 32 bits; any clamp sets the clipped flag of that tick.
// ----------------------------------------------------------------------------
module observer_consensus_speed_controller_top #(
   parameter int FRAC_BITS       = 16,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   ocsc_req_if.sink                           req_chan,
   ocsc_rsp_if.source                         rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [ocsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ocsc_pkg::CFG_W-1:0]         csr_wr_data
);
   import ocsc_pkg::*;

   localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
   localparam int M_W   = 16;
   localparam int RCP_SHIFT = 20;
   // reciprocal of 12, exact for quotients of values below 2^17
   localparam logic [16:0] RCP12 = 17'((2**RCP_SHIFT + 11) / 12);
   // weight is zero when 2*theta*age reaches 12
   localparam longint unsigned HALF_LIM = 64'd6 << (2 * FRAC_BITS);

   // sequencer
   state_type        state_ff, state_in;
   logic [1:0]       agent_ff, agent_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // configuration and tick operands
   logic [CFG_W-1:0] theta_ff, theta_in;
   logic [CFG_W-1:0] lambda_ff, lambda_in;
   logic [CFG_W-1:0] dt_ff, dt_in;
   logic signed [POS_W-1:0] meas_ff [3];
   logic signed [POS_W-1:0] meas_in [3];
   logic [CFG_W-1:0] age_ff [3];
   logic [CFG_W-1:0] age_in [3];

   // estimator state
   logic signed [POS_W-1:0] est_pos_ff [3];
   logic signed [POS_W-1:0] est_pos_in [3];
   logic signed [POS_W-1:0] est_vel_ff [3];
   logic signed [POS_W-1:0] est_vel_in [3];
   logic signed [POS_W-1:0] acc_ff, acc_in;
   logic                    clip_ff, clip_in;

   // working registers
   logic [47:0]             gp_age_ff, gp_age_in;
   logic [63:0]             part_ff, part_in;
   logic [M_W-1:0]          m_ff, m_in;
   logic                    wzero_ff, wzero_in;
   logic [FRAC_BITS:0]      weight_ff, weight_in;
   logic signed [POS_W-1:0] z_ff, z_in;
   logic signed [POS_W-1:0] t_ff, t_in;
   logic signed [POS_W-1:0] v_ff, v_in;
   logic signed [POS_W-1:0] gp_ff, gp_in;
   logic signed [POS_W-1:0] gv_ff, gv_in;

   // result register
   logic signed [POS_W-1:0] out_speed_ff, out_speed_in;
   logic                    out_clip_ff, out_clip_in;

   // shared multiplier
   logic signed [OP_A_W-1:0] op_a;
   logic        [OP_B_W-1:0] op_b;
   logic signed [PROD_W-1:0] prod;
   sat_type                  mq;

   ocsc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .op_a (op_a),
      .op_b (op_b),
      .prod (prod),
      .q    (mq)
   );

   logic [IDX_W-1:0]   rom_addr;
   logic [FRAC_BITS:0] rom_data;

   ocsc_exp_rom #(.FRAC_BITS(FRAC_BITS), .DEPTH(EXP_TABLE_DEPTH)) u_rom (
      .addr (rom_addr),
      .data (rom_data)
   );

   logic [32:0]       quot;
   logic [63:0]       n_full;
   sat_type           s1, s2;
   logic signed [POS_W:0] diff;

   assign quot     = 33'(m_ff) * 33'(RCP12);
   assign rom_addr = quot[RCP_SHIFT +: IDX_W];
   assign diff     = 33'(est_pos_ff[agent_ff]) - 33'(meas_ff[agent_ff]);
   assign n_full   = (64'(prod[36:0]) << 24) + part_ff;

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.speed_command = out_speed_ff;
   assign rsp_chan.clipped       = out_clip_ff;

   always_comb begin
      state_in     = state_ff;
      agent_in     = agent_ff;
      rsp_valid_in = rsp_valid_ff;
      theta_in     = theta_ff;
      lambda_in    = lambda_ff;
      dt_in        = dt_ff;
      meas_in      = meas_ff;
      age_in       = age_ff;
      est_pos_in   = est_pos_ff;
      est_vel_in   = est_vel_ff;
      acc_in       = acc_ff;
      clip_in      = clip_ff;
      gp_age_in    = gp_age_ff;
      part_in      = part_ff;
      m_in         = m_ff;
      wzero_in     = wzero_ff;
      weight_in    = weight_ff;
      z_in         = z_ff;
      t_in         = t_ff;
      v_in         = v_ff;
      gp_in        = gp_ff;
      gv_in        = gv_ff;
      out_speed_in = out_speed_ff;
      out_clip_in  = out_clip_ff;
      op_a         = '0;
      op_b         = '0;
      s1           = '0;
      s2           = '0;

      // drop the result once taken
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_OBSERVER_GAIN:  theta_in  = csr_wr_data;
            CSR_CONSENSUS_GAIN: lambda_in = csr_wr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               dt_in      = req_chan.tick_interval;
               meas_in[0] = req_chan.pos_self;
               meas_in[1] = req_chan.pos_first_nbr;
               meas_in[2] = req_chan.pos_second_nbr;
               age_in[0]  = req_chan.age_self;
               age_in[1]  = req_chan.age_first_nbr;
               age_in[2]  = req_chan.age_second_nbr;
               agent_in   = 2'd0;
               clip_in    = 1'b0;
               state_in   = ST_PROD;
            end
         end
         ST_PROD: begin
            // theta * age
            op_a      = OP_A_W'(theta_ff);
            op_b      = OP_B_W'(age_ff[agent_ff]);
            gp_age_in = prod[47:0];
            state_in  = ST_IDX_LO;
         end
         ST_IDX_LO: begin
            op_a     = OP_A_W'(gp_age_ff[23:0]);
            op_b     = OP_B_W'(EXP_TABLE_DEPTH);
            part_in  = 64'(prod[36:0]);
            state_in = ST_IDX_HI;
         end
         ST_IDX_HI: begin
            // scale 2*theta*age*DEPTH down to a value below 12*DEPTH
            op_a     = OP_A_W'(gp_age_ff[47:24]);
            op_b     = OP_B_W'(EXP_TABLE_DEPTH);
            m_in     = M_W'(n_full >> (2 * FRAC_BITS - 1));
            wzero_in = (64'(gp_age_ff) >= HALF_LIM);
            state_in = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            weight_in = wzero_ff ? '0 : rom_data;
            state_in  = ST_ERR;
         end
         ST_ERR: begin
            op_a     = OP_A_W'(diff);
            op_b     = OP_B_W'(weight_ff);
            z_in     = mq.value;
            clip_in  = clip_ff | mq.clip;
            state_in = ST_GAIN_Z;
         end
         ST_GAIN_Z: begin
            op_a     = OP_A_W'(z_ff);
            op_b     = OP_B_W'(theta_ff);
            t_in     = mq.value;
            clip_in  = clip_ff | mq.clip;
            state_in = ST_DVEL;
         end
         ST_DVEL: begin
            op_a     = OP_A_W'(t_ff);
            op_b     = OP_B_W'(theta_ff);
            s1       = sat32(-64'(mq.value));
            t_in     = s1.value;
            clip_in  = clip_ff | mq.clip | s1.clip;
            state_in = ST_VEL;
         end
         ST_VEL: begin
            op_a     = OP_A_W'(t_ff);
            op_b     = OP_B_W'(dt_ff);
            s1       = sat32(64'(est_vel_ff[agent_ff]) + 64'(mq.value));
            v_in     = s1.value;
            clip_in  = clip_ff | mq.clip | s1.clip;
            state_in = ST_DPOS;
         end
         ST_DPOS: begin
            op_a     = OP_A_W'(z_ff);
            op_b     = {theta_ff, 1'b0};
            s1       = sat32(64'(v_ff) - 64'(mq.value));
            t_in     = s1.value;
            clip_in  = clip_ff | mq.clip | s1.clip;
            state_in = ST_POS;
         end
         ST_POS: begin
            op_a     = OP_A_W'(t_ff);
            op_b     = OP_B_W'(dt_ff);
            s1       = sat32(64'(est_pos_ff[agent_ff]) + 64'(mq.value));
            est_pos_in[agent_ff] = s1.value;
            est_vel_in[agent_ff] = v_ff;
            clip_in  = clip_ff | mq.clip | s1.clip;
            // advance to the next agent or to the consensus step
            if (agent_ff == 2'd2) begin
               state_in = ST_GAP;
            end else begin
               agent_in = agent_ff + 2'd1;
               state_in = ST_PROD;
            end
         end
         ST_GAP: begin
            s1 = sat32((64'(est_pos_ff[0]) <<< 1) - 64'(est_pos_ff[1])
                       - 64'(est_pos_ff[2]));
            s2 = sat32((64'(est_vel_ff[0]) <<< 1) - 64'(est_vel_ff[1])
                       - 64'(est_vel_ff[2]));
            gp_in    = s1.value;
            gv_in    = s2.value;
            clip_in  = clip_ff | s1.clip | s2.clip;
            state_in = ST_PGAIN1;
         end
         ST_PGAIN1: begin
            op_a     = OP_A_W'(gp_ff);
            op_b     = OP_B_W'(lambda_ff);
            t_in     = mq.value;
            clip_in  = clip_ff | mq.clip;
            state_in = ST_PGAIN2;
         end
         ST_PGAIN2: begin
            op_a     = OP_A_W'(t_ff);
            op_b     = OP_B_W'(lambda_ff);
            t_in     = mq.value;
            clip_in  = clip_ff | mq.clip;
            state_in = ST_VGAIN;
         end
         ST_VGAIN: begin
            op_a     = OP_A_W'(gv_ff);
            op_b     = OP_B_W'(lambda_ff);
            s1       = sat32(-64'(t_ff) - 64'(mq.value));
            t_in     = s1.value;
            clip_in  = clip_ff | mq.clip | s1.clip;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            op_a     = OP_A_W'(t_ff);
            op_b     = OP_B_W'(dt_ff);
            s1       = sat32(64'(acc_ff) + 64'(mq.value));
            acc_in   = s1.value;
            clip_in  = clip_ff | mq.clip | s1.clip;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_speed_in = acc_ff;
               out_clip_in  = clip_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         agent_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
         theta_ff     <= OBSERVER_GAIN_RST;
         lambda_ff    <= CONSENSUS_GAIN_RST;
         est_pos_ff   <= '{default: '0};
         est_vel_ff   <= '{default: '0};
         acc_ff       <= '0;
         clip_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         agent_ff     <= agent_in;
         rsp_valid_ff <= rsp_valid_in;
         theta_ff     <= theta_in;
         lambda_ff    <= lambda_in;
         est_pos_ff   <= est_pos_in;
         est_vel_ff   <= est_vel_in;
         acc_ff       <= acc_in;
         clip_ff      <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff        <= dt_in;
      meas_ff      <= meas_in;
      age_ff       <= age_in;
      gp_age_ff    <= gp_age_in;
      part_ff      <= part_in;
      m_ff         <= m_in;
      wzero_ff     <= wzero_in;
      weight_ff    <= weight_in;
      z_ff         <= z_in;
      t_ff         <= t_in;
      v_ff         <= v_in;
      gp_ff        <= gp_in;
      gv_ff        <= gv_in;
      out_speed_ff <= out_speed_in;
      out_clip_ff  <= out_clip_in;
   end
endmodule

// File: sv/ocsc_exp_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocsc_exp_rom
// Constant table of exp(-12*i/DEPTH), built at elaboration.
// ----------------------------------------------------------------------------
module ocsc_exp_rom #(
   parameter int FRAC_BITS = 16,
   parameter int DEPTH     = 256
) (
   input  logic [$clog2(DEPTH)-1:0] addr,
   output logic [FRAC_BITS:0]       data
);
   function automatic longint unsigned exp_entry(input int idx);
      longint unsigned h;
      longint unsigned term;
      longint          e;
      longint unsigned c;
      h    = (64'd12 << 32) / 64'(DEPTH);
      term = 64'd1 << 32;
      e    = 64'sd1 <<< 32;
      c    = 64'd1 << 32;
      for (int k = 1; k <= 24; k++) begin
         term = ((term * h) >> 32) / 64'(k);
         if (k % 2 == 1) e = e - longint'(term);
         else            e = e + longint'(term);
      end
      for (int i = 0; i < idx; i++) begin
         c = (c * longint'(e) + (64'd1 << 31)) >> 32;
      end
      return (c + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
   endfunction

   logic [FRAC_BITS:0] rom [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_entry
      localparam longint unsigned ENTRY = exp_entry(g);
      assign rom[g] = ENTRY[FRAC_BITS:0];
   end

   assign data = rom[addr];
endmodule

// File: sv/ocsc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocsc_mul
// Shared multiplier: signed by unsigned product, floor shift and clamp.
// ----------------------------------------------------------------------------
module ocsc_mul #(
   parameter int FRAC_BITS = 16
) (
   input  logic signed [ocsc_pkg::OP_A_W-1:0]   op_a,
   input  logic        [ocsc_pkg::OP_B_W-1:0]   op_b,
   output logic signed [ocsc_pkg::PROD_W-1:0]   prod,
   output ocsc_pkg::sat_type                    q
);
   import ocsc_pkg::*;

   logic signed [PROD_W-1:0] shifted;

   assign prod    = PROD_W'(op_a) * PROD_W'($signed({1'b0, op_b}));
   // arithmetic shift floors toward minus infinity
   assign shifted = prod >>> FRAC_BITS;
   assign q       = sat32(64'(shifted));
endmodule
